[hw/rtl/look_at_view_matrix_top_defines.svh]
// Assertion macros for the look-at view matrix block
`ifndef LOOK_AT_VIEW_MATRIX_TOP_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_DEFINES_SVH
`ifndef SYNTH
`define LAVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LAVM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define LAVM_ASSERT(lbl, prop, msg)
`define LAVM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[hw/rtl/lavm_pkg.sv]
// Shared constants and types for the look-at view matrix block
package lavm_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned MagW        = 30;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned RootW       = 64;
  localparam int unsigned LenW        = 32;

  typedef enum logic [1:0] {
    CfgUpX = 2'd0,
    CfgUpY = 2'd1,
    CfgUpZ = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RowA = 2'd0,
    RowB = 2'd1,
    RowC = 2'd2,
    RowD = 2'd3
  } row_e;

endpackage

[hw/rtl/lavm_norm.sv]
// Pipelined three-component vector normaliser: scale, square root, divide
module lavm_norm #(
  parameter int unsigned W        = 33,
  parameter int unsigned PW       = 1,
  parameter int unsigned FracBits = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2:0][W-1:0]        v_i,
  input  logic [PW-1:0]            pl_i,
  output logic                     valid_o,
  output logic [2:0][FracBits+1:0] o_o,
  output logic                     zero_o,
  output logic [PW-1:0]            pl_o
);
  import lavm_pkg::*;

  localparam int unsigned PosW = $clog2(W);
  localparam int unsigned QB   = FracBits + 1;
  localparam int unsigned ZW   = FracBits + 2;
  localparam int unsigned NW   = MagW + FracBits + 1;
  localparam int unsigned CW   = PW + 4;

  // stage 1: magnitudes
  logic                 s1_v_q;
  logic [2:0][W-1:0]    s1_m_q, m_d;
  logic [2:0]           neg_d;
  logic [CW-1:0]        s1_c_q, c_d;
  // stage 2: largest magnitude
  logic                 s2_v_q;
  logic [2:0][W-1:0]    s2_m_q;
  logic [W-1:0]         s2_top_q, top_d;
  logic [CW-1:0]        s2_c_q;
  // stage 3: shift amount
  logic                 s3_v_q;
  logic [2:0][W-1:0]    s3_m_q;
  logic                 s3_right_q, right_d;
  logic [PosW-1:0]      s3_amt_q, amt_d, pos;
  logic [CW-1:0]        s3_c_q;
  // stage 4: scaled magnitudes
  logic                 s4_v_q;
  logic [2:0][MagW-1:0] s4_m_q, m4_d;
  logic [CW-1:0]        s4_c_q;
  // stage 5: squares
  logic                 s5_v_q;
  logic [2:0][MagW-1:0] s5_m_q;
  logic [2:0][2*MagW-1:0] s5_sq_q, sq_d;
  logic [CW-1:0]        s5_c_q;
  // square root chain
  logic                 sv_q [SqrtSteps+1];
  logic [RootW-1:0]     sn_q [SqrtSteps+1];
  logic [RootW-1:0]     sr_q [SqrtSteps+1];
  logic [2:0][MagW-1:0] sm_q [SqrtSteps+1];
  logic [CW-1:0]        sc_q [SqrtSteps+1];
  // divider chain
  logic                 dv_q   [QB+1];
  logic [2:0][LenW-1:0] drem_q [QB+1];
  logic [2:0][QB-1:0]   dnl_q  [QB+1];
  logic [2:0][QB-1:0]   dq_q   [QB+1];
  logic [LenW-1:0]      dl_q   [QB+1];
  logic [CW-1:0]        dc_q   [QB+1];
  logic [2:0][LenW-1:0] drem0_d;
  logic [2:0][QB-1:0]   dnl0_d;
  logic [LenW-1:0]      len0;
  logic [NW-1:0]        num;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = v_i[k][W-1];
      m_d[k]   = v_i[k][W-1] ? (~v_i[k] + 1'b1) : v_i[k];
    end
    c_d = {pl_i, (v_i == '0), neg_d};
  end

  always_comb begin
    top_d = s1_m_q[0];
    if (s1_m_q[1] > top_d) top_d = s1_m_q[1];
    if (s1_m_q[2] > top_d) top_d = s1_m_q[2];
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < W; i++) begin
      if (s2_top_q[i]) pos = PosW'(i);
    end
    right_d = pos > PosW'(MagW - 1);
    amt_d   = right_d ? (pos - PosW'(MagW - 1)) : (PosW'(MagW - 1) - pos);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m4_d[k] = s3_right_q ? MagW'(s3_m_q[k] >> s3_amt_q) : MagW'(s3_m_q[k] << s3_amt_q);
      sq_d[k] = s4_m_q[k] * s4_m_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      sv_q[0] <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_m_q     <= m_d;
      s1_c_q     <= c_d;
      s2_m_q     <= s1_m_q;
      s2_top_q   <= top_d;
      s2_c_q     <= s1_c_q;
      s3_m_q     <= s2_m_q;
      s3_right_q <= right_d;
      s3_amt_q   <= amt_d;
      s3_c_q     <= s2_c_q;
      s4_m_q     <= m4_d;
      s4_c_q     <= s3_c_q;
      s5_m_q     <= s4_m_q;
      s5_sq_q    <= sq_d;
      s5_c_q     <= s4_c_q;
      sn_q[0]    <= RootW'(s5_sq_q[0]) + RootW'(s5_sq_q[1]) + RootW'(s5_sq_q[2]);
      sr_q[0]    <= '0;
      sm_q[0]    <= s5_m_q;
      sc_q[0]    <= s5_c_q;
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_root
    logic [RootW-1:0] bt, trial, n_d, r_d;
    always_comb begin
      bt    = RootW'(1) << (2 * (SqrtSteps - 1 - j));
      trial = sr_q[j] + bt;
      if (sn_q[j] >= trial) begin
        n_d = sn_q[j] - trial;
        r_d = (sr_q[j] >> 1) + bt;
      end else begin
        n_d = sn_q[j];
        r_d = sr_q[j] >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[j+1] <= sv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q[j+1] <= n_d;
        sr_q[j+1] <= r_d;
        sm_q[j+1] <= sm_q[j];
        sc_q[j+1] <= sc_q[j];
      end
    end
  end

  always_comb begin
    len0 = LenW'(sr_q[SqrtSteps]);
    num  = '0;
    for (int k = 0; k < 3; k++) begin
      num        = (NW'(sm_q[SqrtSteps][k]) << FracBits) + NW'(len0 >> 1);
      drem0_d[k] = LenW'(num >> QB);
      dnl0_d[k]  = num[QB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0] <= drem0_d;
      dnl_q[0]  <= dnl0_d;
      dq_q[0]   <= '0;
      dl_q[0]   <= len0;
      dc_q[0]   <= sc_q[SqrtSteps];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [2:0][LenW-1:0] rem_d;
    logic [2:0][QB-1:0]   q_d, nl_d;
    logic [LenW:0]        part;
    always_comb begin
      part = '0;
      for (int k = 0; k < 3; k++) begin
        part    = {drem_q[j][k], dnl_q[j][k][QB-1]};
        nl_d[k] = dnl_q[j][k] << 1;
        if (part >= {1'b0, dl_q[j]}) begin
          rem_d[k] = LenW'(part - {1'b0, dl_q[j]});
          q_d[k]   = {dq_q[j][k][QB-2:0], 1'b1};
        end else begin
          rem_d[k] = LenW'(part);
          q_d[k]   = {dq_q[j][k][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[j+1] <= rem_d;
        dnl_q[j+1]  <= nl_d;
        dq_q[j+1]   <= q_d;
        dl_q[j+1]   <= dl_q[j];
        dc_q[j+1]   <= dc_q[j];
      end
    end
  end

  assign valid_o = dv_q[QB];
  assign zero_o  = dc_q[QB][3];
  assign pl_o    = dc_q[QB][CW-1:4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (zero_o) begin
        o_o[k] = '0;
      end else if (dc_q[QB][k]) begin
        o_o[k] = ~{1'b0, dq_q[QB][k]} + 1'b1;
      end else begin
        o_o[k] = ZW'({1'b0, dq_q[QB][k]});
      end
    end
  end

endmodule

[hw/rtl/look_at_view_matrix_top.sv]
// Top level of the right-handed look-at view matrix pipeline
//
//  channel   dir  fields (lowest bit up)                                  transfer when
//  s_axis    in   tdata: eye_x, eye_y, eye_z, target_x, target_y, target_z  tvalid & tready
//  m_axis    out  tdata: row_index, col_first, col_second, col_third, pad   tvalid & tready
//                 tlast: last_row   tuser: degenerate
//  cfg       in   cfg_idx_i selects up_x, up_y, up_z; cfg_data_i value      cfg_we_i
//
//  Four output rows per item; the row serialiser at the output takes a new item as
//  its last row is transferred. Two normalisers of FracBits + 40 stages each lie
//  between the input transfer and row 0. Reset clears all valid bits and loads
//  up = (0, 1.0, 0); no clearing pass. A stall at the output with an item in the
//  last stage freezes every stage at once; nothing is dropped or repeated.
`include "look_at_view_matrix_top_defines.svh"
module look_at_view_matrix_top #(
  parameter int unsigned FracBits = lavm_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z
  input  logic [6*lavm_pkg::DataW-1:0] s_axis_tdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // row_index, col_first, col_second, col_third, zero pad
  output logic [103:0]              m_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic                      m_axis_tlast,
  // degenerate
  output logic                      m_axis_tuser,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [lavm_pkg::DataW-1:0] cfg_data_i
);
  import lavm_pkg::*;

  localparam int unsigned ZW   = FracBits + 2;
  localparam int unsigned PCW  = DataW + ZW;
  localparam int unsigned XW   = PCW + 1;
  localparam int unsigned YPW  = 2 * ZW;
  localparam int unsigned YDW  = YPW + 1;
  localparam int unsigned RWX  = (YDW > 33) ? YDW : 33;
  localparam int unsigned SW   = 2 * DataW + 2;
  localparam int unsigned EW   = 3 * DataW;
  localparam int unsigned N2PW = EW + 3 * ZW + 1;
  localparam logic [DataW-1:0] UpYReset = DataW'(1) << FracBits;
  localparam logic [DataW-1:0] MaxPos   = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinNeg   = {1'b1, {(DataW-1){1'b0}}};

  logic adv, take;

  // configuration
  logic [2:0][DataW-1:0] up_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= '0;
      up_q[1] <= UpYReset;
      up_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUpX:  up_q[0] <= cfg_data_i;
        CfgUpY:  up_q[1] <= cfg_data_i;
        CfgUpZ:  up_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage: eye minus target
  logic                   p0_v_q;
  logic [2:0][DataW-1:0]  p0_eye_q, eye_d;
  logic [2:0][DataW:0]    p0_d_q, diff_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eye_d[k]  = s_axis_tdata[k*DataW +: DataW];
      diff_d[k] = {eye_d[k][DataW-1], eye_d[k]}
                - {s_axis_tdata[(k+3)*DataW + DataW-1], s_axis_tdata[(k+3)*DataW +: DataW]};
    end
  end

  // forward axis
  logic                n1_v, n1_zero;
  logic [2:0][ZW-1:0]  n1_z;
  logic [EW-1:0]       n1_eye;
  lavm_norm #(.W(DataW + 1), .PW(EW), .FracBits(FracBits)) u_norm_fwd (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p0_v_q), .v_i(p0_d_q), .pl_i(p0_eye_q),
    .valid_o(n1_v), .o_o(n1_z), .zero_o(n1_zero), .pl_o(n1_eye)
  );

  // up cross forward
  logic                    c1_v_q, c1_bad_q;
  logic signed [PCW-1:0]   c1_p_q [6];
  logic signed [PCW-1:0]   c1_p_d [6];
  logic [2:0][ZW-1:0]      c1_z_q;
  logic [EW-1:0]           c1_eye_q;
  always_comb begin
    c1_p_d[0] = $signed(up_q[1]) * $signed(n1_z[2]);
    c1_p_d[1] = $signed(up_q[2]) * $signed(n1_z[1]);
    c1_p_d[2] = $signed(up_q[2]) * $signed(n1_z[0]);
    c1_p_d[3] = $signed(up_q[0]) * $signed(n1_z[2]);
    c1_p_d[4] = $signed(up_q[0]) * $signed(n1_z[1]);
    c1_p_d[5] = $signed(up_q[1]) * $signed(n1_z[0]);
  end

  logic                 c2_v_q, c2_bad_q;
  logic [2:0][XW-1:0]   c2_x_q, c2_x_d;
  logic [2:0][ZW-1:0]   c2_z_q;
  logic [EW-1:0]        c2_eye_q;
  logic signed [XW-1:0] xr [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xr[k]     = c1_p_q[2*k] - c1_p_q[2*k+1];
      c2_x_d[k] = xr[k];
    end
  end

  // right axis
  logic                n2_v, n2_zero;
  logic [2:0][ZW-1:0]  n2_x, n2_z;
  logic [N2PW-1:0]     n2_pl;
  logic [EW-1:0]       n2_eye;
  logic                n2_bad;
  lavm_norm #(.W(XW), .PW(N2PW), .FracBits(FracBits)) u_norm_right (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(c2_v_q), .v_i(c2_x_q),
    .pl_i({c2_bad_q, c2_z_q, c2_eye_q}),
    .valid_o(n2_v), .o_o(n2_x), .zero_o(n2_zero), .pl_o(n2_pl)
  );
  assign n2_eye = n2_pl[EW-1:0];
  assign n2_z   = n2_pl[EW +: 3*ZW];
  assign n2_bad = n2_pl[N2PW-1] | n2_zero;

  // up axis: forward cross right
  logic                  y1_v_q, y1_bad_q;
  logic signed [YPW-1:0] y1_p_q [6];
  logic signed [YPW-1:0] y1_p_d [6];
  logic [2:0][ZW-1:0]    y1_x_q, y1_z_q;
  logic [EW-1:0]         y1_eye_q;
  always_comb begin
    y1_p_d[0] = $signed(n2_z[1]) * $signed(n2_x[2]);
    y1_p_d[1] = $signed(n2_z[2]) * $signed(n2_x[1]);
    y1_p_d[2] = $signed(n2_z[2]) * $signed(n2_x[0]);
    y1_p_d[3] = $signed(n2_z[0]) * $signed(n2_x[2]);
    y1_p_d[4] = $signed(n2_z[0]) * $signed(n2_x[1]);
    y1_p_d[5] = $signed(n2_z[1]) * $signed(n2_x[0]);
  end

  logic                  y2_v_q, y2_bad_q;
  logic signed [YDW-1:0] y2_s_q [3];
  logic signed [YDW-1:0] y2_s_d [3];
  logic [2:0][ZW-1:0]    y2_x_q, y2_z_q;
  logic [EW-1:0]         y2_eye_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      y2_s_d[k] = y1_p_q[2*k] - y1_p_q[2*k+1];
    end
  end

  // rescale up axis, widen x and z
  logic                  y3_v_q, y3_bad_q;
  logic [2:0][DataW-1:0] y3_a_q [3];
  logic [2:0][DataW-1:0] y3_a_d [3];
  logic [EW-1:0]         y3_eye_q;
  logic [RWX-1:0]        ymag, yrnd;
  always_comb begin
    ymag = '0;
    yrnd = '0;
    for (int k = 0; k < 3; k++) begin
      y3_a_d[0][k] = DataW'($signed(y2_x_q[k]));
      y3_a_d[2][k] = DataW'($signed(y2_z_q[k]));
      ymag = y2_s_q[k][YDW-1] ? RWX'(-y2_s_q[k]) : RWX'(y2_s_q[k]);
      ymag = ymag & ((RWX'(1) << YDW) - RWX'(1));
      yrnd = (ymag + (RWX'(1) << (FracBits - 1))) >> FracBits;
      if (y2_s_q[k][YDW-1]) begin
        y3_a_d[1][k] = (yrnd > RWX'(MinNeg)) ? MinNeg : DataW'(~yrnd + 1'b1);
      end else begin
        y3_a_d[1][k] = (yrnd > RWX'(MaxPos)) ? MaxPos : DataW'(yrnd);
      end
    end
  end

  // negated dot products with the eye
  logic                   d1_v_q, d1_bad_q;
  logic signed [2*DataW-1:0] d1_p_q [3][3];
  logic signed [2*DataW-1:0] d1_p_d [3][3];
  logic [2:0][DataW-1:0]  d1_a_q [3];
  logic [2:0][DataW-1:0]  y3_eye;
  assign y3_eye = y3_eye_q;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        d1_p_d[c][i] = $signed(y3_a_q[c][i]) * $signed(y3_eye[i]);
      end
    end
  end

  logic                 d2_v_q, d2_bad_q;
  logic signed [SW-1:0] d2_s_q [3];
  logic signed [SW-1:0] d2_s_d [3];
  logic [2:0][DataW-1:0] d2_a_q [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d2_s_d[c] = SW'(d1_p_q[c][0]) + SW'(d1_p_q[c][1]) + SW'(d1_p_q[c][2]);
    end
  end

  logic [2:0][DataW-1:0] w_d;
  logic [SW-1:0]         dmag, drnd;
  always_comb begin
    dmag = '0;
    drnd = '0;
    for (int c = 0; c < 3; c++) begin
      dmag = d2_s_q[c][SW-1] ? SW'(-d2_s_q[c]) : SW'(d2_s_q[c]);
      drnd = (dmag + (SW'(1) << (FracBits - 1))) >> FracBits;
      if (d2_s_q[c][SW-1] || (d2_s_q[c] == '0)) begin
        w_d[c] = (drnd > SW'(MaxPos)) ? MaxPos : DataW'(drnd);
      end else begin
        w_d[c] = (drnd > SW'(MinNeg)) ? MinNeg : DataW'(~drnd + 1'b1);
      end
    end
  end

  // row serialiser
  logic                  ser_v_q, ser_bad_q;
  row_e                  row_q;
  logic [2:0][DataW-1:0] ser_a_q [3];
  logic [2:0][DataW-1:0] ser_w_q;
  logic [DataW-1:0]      col0, col1, col2;

  assign take          = !ser_v_q || (m_axis_tready && (row_q == RowD));
  assign adv           = !d2_v_q || take;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      y1_v_q <= 1'b0;
      y2_v_q <= 1'b0;
      y3_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
    end else if (adv) begin
      p0_v_q <= s_axis_tvalid;
      c1_v_q <= n1_v;
      c2_v_q <= c1_v_q;
      y1_v_q <= n2_v;
      y2_v_q <= y1_v_q;
      y3_v_q <= y2_v_q;
      d1_v_q <= y3_v_q;
      d2_v_q <= d1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_eye_q <= eye_d;
      p0_d_q   <= diff_d;
      c1_p_q   <= c1_p_d;
      c1_z_q   <= n1_z;
      c1_eye_q <= n1_eye;
      c1_bad_q <= n1_zero;
      c2_x_q   <= c2_x_d;
      c2_z_q   <= c1_z_q;
      c2_eye_q <= c1_eye_q;
      c2_bad_q <= c1_bad_q;
      y1_p_q   <= y1_p_d;
      y1_x_q   <= n2_x;
      y1_z_q   <= n2_z;
      y1_eye_q <= n2_eye;
      y1_bad_q <= n2_bad;
      y2_s_q   <= y2_s_d;
      y2_x_q   <= y1_x_q;
      y2_z_q   <= y1_z_q;
      y2_eye_q <= y1_eye_q;
      y2_bad_q <= y1_bad_q;
      y3_a_q   <= y3_a_d;
      y3_eye_q <= y2_eye_q;
      y3_bad_q <= y2_bad_q;
      d1_p_q   <= d1_p_d;
      d1_a_q   <= y3_a_q;
      d1_bad_q <= y3_bad_q;
      d2_s_q   <= d2_s_d;
      d2_a_q   <= d1_a_q;
      d2_bad_q <= d1_bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      row_q   <= RowA;
    end else if (take) begin
      ser_v_q <= d2_v_q;
      row_q   <= RowA;
    end else if (m_axis_tready) begin
      row_q   <= row_e'(row_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ser_a_q   <= d2_a_q;
      ser_w_q   <= w_d;
      ser_bad_q <= d2_bad_q;
    end
  end

  always_comb begin
    case (row_q)
      RowA: begin
        col0 = ser_a_q[0][0];
        col1 = ser_a_q[1][0];
        col2 = ser_a_q[2][0];
      end
      RowB: begin
        col0 = ser_a_q[0][1];
        col1 = ser_a_q[1][1];
        col2 = ser_a_q[2][1];
      end
      RowC: begin
        col0 = ser_a_q[0][2];
        col1 = ser_a_q[1][2];
        col2 = ser_a_q[2][2];
      end
      default: begin
        col0 = ser_w_q[0];
        col1 = ser_w_q[1];
        col2 = ser_w_q[2];
      end
    endcase
  end

  assign m_axis_tvalid = ser_v_q;
  assign m_axis_tdata  = {6'd0, col2, col1, col0, row_q};
  assign m_axis_tlast  = (row_q == RowD);
  assign m_axis_tuser  = ser_bad_q;

  `LAVM_ASSERT_NEXT(a_rows_continue, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)), "matrix rows broken up")
  `LAVM_ASSERT_NEXT(a_row_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1, "row index skipped")
  `LAVM_ASSERT(a_stall_holds_input, (d2_v_q && !take) |-> !s_axis_tready, "input taken during stall")
  `LAVM_ASSERT_NEXT(a_load_row_a, take && d2_v_q, ser_v_q && (row_q == RowA), "new matrix not at row 0")

endmodule
